// File: src/sacl_pkg.sv
// Shared types and constants for the set-associative cache LRU tracker.
// No dependencies; imported by every module of the block except sacl_ram.
package sacl_pkg;

	localparam int CNT_W          = 32;
	localparam int CFG_SB_W       = 4;
	localparam int CFG_BB_W       = 6;
	localparam int CFG_WAYS_W     = 4;
	localparam int SB_W           = 5;
	localparam int BB_W           = 6;
	localparam int WAYS_W         = 5;
	localparam int MAX_BLOCK_BITS = 32;

	localparam logic [CFG_SB_W-1:0]   RST_SET_BITS   = 4'd4;
	localparam logic [CFG_BB_W-1:0]   RST_BLOCK_BITS = 6'd4;
	localparam logic [CFG_WAYS_W-1:0] RST_WAYS       = 4'd1;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_INSTR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		OUT_HIT     = 2'd0,
		OUT_FILL    = 2'd1,
		OUT_EVICT   = 2'd2,
		OUT_IGNORED = 2'd3
	} outcome_t;

	typedef struct packed {
		logic [SB_W-1:0]   set_bits;
		logic [BB_W-1:0]   block_bits;
		logic [WAYS_W-1:0] ways;
	} geom_t;

	typedef struct packed {
		outcome_t outcome;
		logic     hit;
		logic     miss;
		logic     evict;
	} lookup_t;

endpackage

// File: src/sacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/sacl_cfg.sv
// APB configuration registers and clamped cache geometry.
// Depends on sacl_pkg.
module sacl_cfg import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output geom_t       geom
);

	logic [CFG_SB_W-1:0]   set_bits_q;
	logic [CFG_BB_W-1:0]   block_bits_q;
	logic [CFG_WAYS_W-1:0] ways_q;
	logic                  wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= RST_SET_BITS;
			block_bits_q <= RST_BLOCK_BITS;
			ways_q       <= RST_WAYS;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_SET_BITS:   set_bits_q   <= pwdata[CFG_SB_W-1:0];
				REG_BLOCK_BITS: block_bits_q <= pwdata[CFG_BB_W-1:0];
				REG_WAYS:       ways_q       <= pwdata[CFG_WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SET_BITS:   prdata = {{(32-CFG_SB_W){1'b0}}, set_bits_q};
			REG_BLOCK_BITS: prdata = {{(32-CFG_BB_W){1'b0}}, block_bits_q};
			REG_WAYS:       prdata = {{(32-CFG_WAYS_W){1'b0}}, ways_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_comb begin
		geom.set_bits = {1'b0, set_bits_q};
		if (geom.set_bits == '0) begin
			geom.set_bits = SB_W'(1);
		end else if (geom.set_bits > SB_W'(MAX_SET_BITS)) begin
			geom.set_bits = SB_W'(MAX_SET_BITS);
		end
		geom.block_bits = block_bits_q;
		if (geom.block_bits == '0) begin
			geom.block_bits = BB_W'(1);
		end else if (geom.block_bits > BB_W'(MAX_BLOCK_BITS)) begin
			geom.block_bits = BB_W'(MAX_BLOCK_BITS);
		end
		geom.ways = {1'b0, ways_q};
		if (geom.ways == '0) begin
			geom.ways = WAYS_W'(1);
		end else if (geom.ways > WAYS_W'(MAX_WAYS)) begin
			geom.ways = WAYS_W'(MAX_WAYS);
		end
	end

endmodule

// File: src/sacl_lookup.sv
// Tag match, fill and victim choice, and LRU rank update for one set row.
// Depends on sacl_pkg.
module sacl_lookup import sacl_pkg::*; #(
	parameter int MAX_WAYS = 8,
	parameter int TAG_W    = 62,
	parameter int RANK_W   = 3
) (
	input  logic [MAX_WAYS*(1+RANK_W+TAG_W)-1:0] row_rd,
	input  logic [TAG_W-1:0]                     tag,
	input  logic [WAYS_W-1:0]                    ways,
	output logic [MAX_WAYS*(1+RANK_W+TAG_W)-1:0] row_wr,
	output lookup_t                              res
);

	localparam int WI      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_LO = MAX_WAYS;
	localparam int TAG_LO  = MAX_WAYS * (1 + RANK_W);

	always_comb begin
		logic [MAX_WAYS-1:0] valid;
		logic [MAX_WAYS-1:0] used;
		logic [RANK_W-1:0]   rank [MAX_WAYS];
		logic [TAG_W-1:0]    tags [MAX_WAYS];
		logic                hit_found;
		logic                free_found;
		logic [WI-1:0]       hit_way;
		logic [WI-1:0]       free_way;
		logic [WI-1:0]       victim;
		logic [RANK_W-1:0]   victim_rank;
		logic [WI-1:0]       sel;
		logic [RANK_W:0]     old;

		for (int i = 0; i < MAX_WAYS; i++) begin
			valid[i] = row_rd[i];
			rank[i]  = row_rd[RANK_LO + i*RANK_W +: RANK_W];
			tags[i]  = row_rd[TAG_LO + i*TAG_W +: TAG_W];
			used[i]  = (ways > WAYS_W'(i));
		end

		hit_found  = 1'b0;
		free_found = 1'b0;
		hit_way    = '0;
		free_way   = '0;
		for (int i = MAX_WAYS-1; i >= 0; i--) begin
			if (used[i] && valid[i] && tags[i] == tag) begin
				hit_found = 1'b1;
				hit_way   = WI'(i);
			end
			if (used[i] && !valid[i]) begin
				free_found = 1'b1;
				free_way   = WI'(i);
			end
		end

		victim      = '0;
		victim_rank = rank[0];
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (used[i] && rank[i] > victim_rank) begin
				victim      = WI'(i);
				victim_rank = rank[i];
			end
		end

		if (hit_found) begin
			sel = hit_way;
			old = {1'b0, rank[hit_way]};
		end else if (free_found) begin
			sel = free_way;
			old = (RANK_W+1)'(MAX_WAYS);
		end else begin
			sel = victim;
			old = {1'b0, victim_rank};
		end

		row_wr = row_rd;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (WI'(i) == sel) begin
				row_wr[i]                          = 1'b1;
				row_wr[RANK_LO + i*RANK_W +: RANK_W] = '0;
				if (!hit_found) begin
					row_wr[TAG_LO + i*TAG_W +: TAG_W] = tag;
				end
			end else if (used[i] && valid[i] && {1'b0, rank[i]} < old
					&& rank[i] < RANK_W'(MAX_WAYS-1)) begin
				row_wr[RANK_LO + i*RANK_W +: RANK_W] = rank[i] + RANK_W'(1);
			end
		end

		res.hit   = hit_found;
		res.miss  = !hit_found;
		res.evict = !hit_found && !free_found;
		if (hit_found) begin
			res.outcome = OUT_HIT;
		end else if (free_found) begin
			res.outcome = OUT_FILL;
		end else begin
			res.outcome = OUT_EVICT;
		end
	end

endmodule

// File: src/set_assoc_cache_lru_tracker.sv
// Top level of the set-associative cache LRU tracker: stream ports, set row memory,
// counters and output register. Depends on sacl_pkg, sacl_ram, sacl_cfg, sacl_lookup.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tuser: cmd; tdata: address
//   m_axis    out  tvalid/tready           tdata: outcome, second_hit, hit/miss/evict totals
//   apb       in   psel/penable/pready     paddr, pwdata, prdata
//
// Each item is handled as a set row read from the memory, then update and write-back.
// The next item is taken only after the write-back, since both go through one memory.
// After reset a clearing pass writes 2^MAX_SET_BITS rows, one per cycle; no item is
// taken meanwhile. A stalled output holds the update stage and blocks new transfers.
module set_assoc_cache_lru_tracker import sacl_pkg::*; #(
	parameter int MAX_SET_BITS = 8,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_BITS    = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,   // address
	input  logic [1:0]   s_axis_tuser,   // cmd
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,   // outcome, second_hit, hit_total, miss_total,
	                                     // evict_total, zero pad
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int TAG_W     = ADDR_BITS - 2;
	localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int ROW_W     = MAX_WAYS * (1 + RANK_W + TAG_W);
	localparam int ROW_COUNT = 1 << MAX_SET_BITS;
	localparam int SET_W     = MAX_SET_BITS;

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, c} + {{(CNT_W-1){1'b0}}, inc};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	geom_t                geom;
	logic                 clr_q;
	logic [SET_W-1:0]     clr_idx_q;
	logic                 acc;
	logic [ADDR_BITS-1:0] addr_m;
	logic [SET_W-1:0]     set_rd;
	logic [TAG_W-1:0]     tag_rd;
	logic [SB_W+1:0]      tag_shift;
	logic                 s1_valid;
	logic                 s1_fire;
	cmd_t                 cmd_s1;
	logic [SET_W-1:0]     set_s1;
	logic [TAG_W-1:0]     tag_s1;
	logic [ROW_W-1:0]     row_rd;
	logic [ROW_W-1:0]     row_wr;
	lookup_t              res;
	logic                 ram_we;
	logic [SET_W-1:0]     ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     miss_cnt_q;
	logic [CNT_W-1:0]     evict_cnt_q;
	logic [CNT_W-1:0]     hit_nx;
	logic [CNT_W-1:0]     miss_nx;
	logic [CNT_W-1:0]     evict_nx;
	logic                 active;
	logic                 modify;
	outcome_t             outcome;
	logic                 m_valid_q;
	logic [103:0]         m_data_q;

	sacl_cfg #(
		.MAX_SET_BITS(MAX_SET_BITS),
		.MAX_WAYS    (MAX_WAYS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.geom   (geom)
	);

	assign s_axis_tready = !clr_q && !s1_valid;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign addr_m        = s_axis_tdata[ADDR_BITS-1:0];
	assign set_rd        = SET_W'(addr_m >> geom.block_bits)
	                       & ~({SET_W{1'b1}} << geom.set_bits);
	assign tag_shift     = {2'b00, geom.set_bits} + {1'b0, geom.block_bits};
	assign tag_rd        = TAG_W'(addr_m >> tag_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + SET_W'(1);
			if (&clr_idx_q) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (acc) begin
			s1_valid <= 1'b1;
		end else if (s1_fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1 <= cmd_t'(s_axis_tuser);
			set_s1 <= set_rd;
			tag_s1 <= tag_rd;
		end
	end

	sacl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(ROW_COUNT)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (acc),
		.raddr(set_rd),
		.rdata(row_rd)
	);

	sacl_lookup #(
		.MAX_WAYS(MAX_WAYS),
		.TAG_W   (TAG_W),
		.RANK_W  (RANK_W)
	) u_lookup (
		.row_rd(row_rd),
		.tag   (tag_s1),
		.ways  (geom.ways),
		.row_wr(row_wr),
		.res   (res)
	);

	assign s1_fire   = s1_valid && (!m_valid_q || m_axis_tready);
	assign active    = cmd_s1 != CMD_INSTR;
	assign modify    = cmd_s1 == CMD_MODIFY;
	assign ram_we    = clr_q || (s1_fire && active);
	assign ram_waddr = clr_q ? clr_idx_q : set_s1;
	assign ram_wdata = clr_q ? '0 : row_wr;

	assign hit_nx   = sat_add(hit_cnt_q, {1'b0, active && res.hit} + {1'b0, modify});
	assign miss_nx  = sat_add(miss_cnt_q, {1'b0, active && res.miss});
	assign evict_nx = sat_add(evict_cnt_q, {1'b0, active && res.evict});
	assign outcome  = active ? res.outcome : OUT_IGNORED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			evict_cnt_q <= '0;
		end else if (s1_fire) begin
			hit_cnt_q   <= hit_nx;
			miss_cnt_q  <= miss_nx;
			evict_cnt_q <= evict_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			m_data_q <= {5'd0, evict_nx, miss_nx, hit_nx, modify, outcome};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && ram_we && !clr_q))
		else $error("row read issued while a write-back is pending");

	a_accept_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> s1_valid && !s_axis_tready)
		else $error("accepted transfer did not enter the update stage");

	a_hit_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> hit_cnt_q >= $past(hit_cnt_q))
		else $error("hit counter wrapped");

	a_miss_step: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> (miss_cnt_q - $past(miss_cnt_q)) <= 32'd1)
		else $error("miss counter stepped by more than one");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(s1_valid))
		else $error("result appeared without an update");

endmodule

// File: verif/tb.sv
// Testbench for set_assoc_cache_lru_tracker: stream accesses under random idling, predicted
// by a tag store mirror with LRU ages and saturating counters, checked field by field.
// Depends on sacl_pkg and the set_assoc_cache_lru_tracker RTL.
module tb import sacl_pkg::*; ();

	localparam int SET_BITS_MAX = 8;
	localparam int WAYS_MAX     = 8;
	localparam int TAG_DEPTH    = (1 << SET_BITS_MAX) * WAYS_MAX;
	localparam int ACCESS_GOAL  = 1500;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	class lru_tag_mirror;
		typedef struct {
			outcome_t  outcome;
			bit        second_hit;
			bit [31:0] hit_total;
			bit [31:0] miss_total;
			bit [31:0] evict_total;
		} result_t;

		bit [3:0]  set_bits_reg;
		bit [5:0]  block_bits_reg;
		bit [3:0]  ways_reg;
		bit        line_valid[TAG_DEPTH];
		bit [63:0] line_tag[TAG_DEPTH];
		int        line_age[TAG_DEPTH];
		bit [31:0] hit_count;
		bit [31:0] miss_count;
		bit [31:0] evict_count;
		result_t   pending_results[$];
		int        errors;

		function new();
			set_bits_reg   = RST_SET_BITS;
			block_bits_reg = RST_BLOCK_BITS;
			ways_reg       = RST_WAYS;
			foreach (line_valid[i]) begin
				line_valid[i] = 1'b0;
				line_tag[i]   = '0;
				line_age[i]   = 0;
			end
			hit_count   = '0;
			miss_count  = '0;
			evict_count = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_SET_BITS:   set_bits_reg   = value[3:0];
				REG_BLOCK_BITS: block_bits_reg = value[5:0];
				REG_WAYS:       ways_reg       = value[3:0];
				default: ;
			endcase
		endfunction

		function int set_width();
			if (set_bits_reg < 1)
				return 1;
			return (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
		endfunction

		function int offset_width();
			if (block_bits_reg < 1)
				return 1;
			return (block_bits_reg > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : int'(block_bits_reg);
		endfunction

		function int way_count();
			if (ways_reg < 1)
				return 1;
			return (ways_reg > WAYS_MAX) ? WAYS_MAX : int'(ways_reg);
		endfunction

		function bit [31:0] saturate_inc(bit [31:0] count);
			return (count == '1) ? count : count + 32'd1;
		endfunction

		function void promote_way(int base, int ways, int way, bit was_valid);
			int old;
			old = was_valid ? line_age[base + way] : WAYS_MAX;
			for (int i = 0; i < ways; i++) begin
				if (i != way && line_valid[base + i] && line_age[base + i] < old &&
				    line_age[base + i] < WAYS_MAX - 1)
					line_age[base + i]++;
			end
			line_age[base + way] = 0;
		endfunction

		function outcome_t look_up(bit [63:0] address);
			int        sbits;
			int        bbits;
			int        ways;
			int        base;
			int        victim;
			bit [63:0] tag;
			sbits = set_width();
			bbits = offset_width();
			ways  = way_count();
			base  = int'((address >> bbits) & ((64'd1 << sbits) - 64'd1)) * WAYS_MAX;
			tag   = address >> (sbits + bbits);
			for (int i = 0; i < ways; i++) begin
				if (line_valid[base + i] && line_tag[base + i] == tag) begin
					promote_way(base, ways, i, 1'b1);
					hit_count = saturate_inc(hit_count);
					return OUT_HIT;
				end
			end
			miss_count = saturate_inc(miss_count);
			for (int i = 0; i < ways; i++) begin
				if (!line_valid[base + i]) begin
					promote_way(base, ways, i, 1'b0);
					line_valid[base + i] = 1'b1;
					line_tag[base + i]   = tag;
					return OUT_FILL;
				end
			end
			victim = 0;
			for (int i = 1; i < ways; i++) begin
				if (line_age[base + i] > line_age[base + victim])
					victim = i;
			end
			promote_way(base, ways, victim, 1'b1);
			line_tag[base + victim] = tag;
			evict_count = saturate_inc(evict_count);
			return OUT_EVICT;
		endfunction

		function void note_access(cmd_t cmd, bit [63:0] address);
			result_t r;
			r.outcome    = OUT_IGNORED;
			r.second_hit = 1'b0;
			if (cmd != CMD_INSTR) begin
				r.outcome = look_up(address);
				if (cmd == CMD_MODIFY) begin
					hit_count    = saturate_inc(hit_count);
					r.second_hit = 1'b1;
				end
			end
			r.hit_total   = hit_count;
			r.miss_total  = miss_count;
			r.evict_total = evict_count;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [103:0] data);
			result_t r;
			if (pending_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", data);
				errors++;
				return;
			end
			r = pending_results.pop_front();
			compare_field("outcome", 32'(r.outcome), 32'(data[1:0]));
			compare_field("second_hit", 32'(r.second_hit), 32'(data[2]));
			compare_field("hit_total", r.hit_total, data[34:3]);
			compare_field("miss_total", r.miss_total, data[66:35]);
			compare_field("evict_total", r.evict_total, data[98:67]);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;   // address
	logic [1:0]   s_axis_tuser;   // cmd
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;   // outcome, second_hit, hit_total, miss_total, evict_total, pad
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	lru_tag_mirror mirror;
	bit            calm;
	int            rx_hold;
	int            cycle_count;
	int            access_count;

	int corner_sbits[7] = '{1, 8, 0, 15, 8, 1, 2};
	int corner_bbits[7] = '{1, 32, 0, 63, 1, 32, 4};
	int corner_ways[7]  = '{1, 8, 0, 15, 2, 8, 4};

	set_assoc_cache_lru_tracker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : int'($urandom_range(0, 12));
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			mirror.check_result(m_axis_tdata);
			rx_hold = draw_gap();
		end else if (rx_hold == 0 && $urandom_range(0, 15) == 0) begin
			rx_hold = draw_gap();
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic logic [63:0] place(logic [63:0] tag, int unsigned set_idx, int sbits,
	                                      int bbits);
		logic [63:0] offset;
		offset = {$urandom, $urandom} & ((64'd1 << bbits) - 64'd1);
		return (tag << (sbits + bbits)) |
		       ((64'(set_idx) & ((64'd1 << sbits) - 64'd1)) << bbits) | offset;
	endfunction

	task automatic send_item(input cmd_t cmd, input logic [63:0] address);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= address;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		mirror.note_access(cmd, address);
		access_count++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (mirror.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mirror.write_reg(idx, value);
	endtask

	task automatic apply_geometry(input int sbits, input int bbits, input int ways);
		settle();
		reg_write(REG_SET_BITS, ($urandom & 32'hFFFF_FFF0) | 32'(sbits & 'hF));
		reg_write(REG_BLOCK_BITS, ($urandom & 32'hFFFF_FFC0) | 32'(bbits & 'h3F));
		reg_write(REG_WAYS, ($urandom & 32'hFFFF_FFF0) | 32'(ways & 'hF));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		int          phase;
		int          phase_len;
		int          sbits;
		int          bbits;
		int          ways;
		int          nsets;
		int unsigned set_base;
		logic [63:0] tag_base;
		logic [63:0] address;
		cmd_t        cmd;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_LOAD;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		mirror        = new();
		calm          = 1'b0;
		access_count  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_item(CMD_LOAD, 64'h0);
		send_item(CMD_LOAD, 64'hF);
		send_item(CMD_STORE, '1);
		send_item(CMD_MODIFY, '1);
		send_item(CMD_INSTR, '1);
		send_item(CMD_LOAD, 64'h100);
		send_item(CMD_MODIFY, 64'h200);
		send_item(CMD_STORE, 64'h8000_0000_0000_0000);
		send_item(CMD_LOAD, 64'h5555_5555_5555_5555);
		send_item(CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);

		// two ways, shrink to one and grow back: duplicate tags, then tied ages
		apply_geometry(4, 4, 2);
		send_item(CMD_LOAD, place(64'd1, 3, 4, 4));
		send_item(CMD_STORE, place(64'd2, 3, 4, 4));
		apply_geometry(4, 4, 1);
		send_item(CMD_LOAD, place(64'd2, 3, 4, 4));
		apply_geometry(4, 4, 2);
		send_item(CMD_LOAD, place(64'd2, 3, 4, 4));
		send_item(CMD_MODIFY, place(64'd3, 3, 4, 4));

		apply_geometry(0, 0, 0);
		send_item(CMD_LOAD, 64'h0);
		send_item(CMD_LOAD, 64'h1);
		send_item(CMD_INSTR, 64'h0);
		apply_geometry(15, 63, 15);
		send_item(CMD_STORE, '1);
		send_item(CMD_MODIFY, '1);
		send_item(CMD_LOAD, 64'h0);

		access_count = 0;
		phase        = 0;
		while (access_count < ACCESS_GOAL) begin
			if (phase < $size(corner_sbits)) begin
				sbits = corner_sbits[phase];
				bbits = corner_bbits[phase];
				ways  = corner_ways[phase];
			end else begin
				sbits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
				bbits = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 32);
				ways  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
			end
			apply_geometry(sbits, bbits, ways);
			calm      = ($urandom_range(0, 3) == 0);
			nsets     = $urandom_range(1, 4);
			set_base  = $urandom;
			tag_base  = {$urandom, $urandom};
			phase_len = $urandom_range(40, 160);
			for (int k = 0; k < phase_len; k++) begin
				if ($urandom_range(0, 99) < 8)
					address = {$urandom, $urandom};
				else
					address = place(tag_base + $urandom_range(0, mirror.way_count() + 2),
					                set_base + $urandom_range(0, nsets - 1),
					                mirror.set_width(), mirror.offset_width());
				cmd = ($urandom_range(0, 7) == 0) ? CMD_INSTR : cmd_t'($urandom_range(0, 2));
				send_item(cmd, address);
			end
			phase++;
		end

		calm = 1'b0;
		settle();
		if (mirror.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: filelist.f
src/sacl_pkg.sv
src/sacl_ram.sv
src/sacl_cfg.sv
src/sacl_lookup.sv
src/set_assoc_cache_lru_tracker.sv
verif/tb.sv
